// ===== design/sou_pkg.sv =====
// sou_pkg: shared types and constants for the stack operator unit
// command and status codes, word structs, cell control struct; no dependencies
`timescale 1ns / 1ps
package sou_pkg;

    localparam int SOU_STACK_DEPTH = 64;

    typedef enum logic [4:0] {
        CMD_PUSH  = 5'd0,
        CMD_ADD   = 5'd1,
        CMD_SUB   = 5'd2,
        CMD_MUL   = 5'd3,
        CMD_DIV   = 5'd4,
        CMD_MOD   = 5'd5,
        CMD_EQ    = 5'd6,
        CMD_NEQ   = 5'd7,
        CMD_GT    = 5'd8,
        CMD_GE    = 5'd9,
        CMD_LT    = 5'd10,
        CMD_LE    = 5'd11,
        CMD_POP   = 5'd12,
        CMD_EXCH  = 5'd13,
        CMD_DUP   = 5'd14,
        CMD_INDEX = 5'd15,
        CMD_ROLL  = 5'd16
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_UNDER    = 3'd1,
        ST_OVER     = 3'd2,
        ST_DIVZERO  = 3'd3,
        ST_BADCOUNT = 3'd4
    } t_status;

    typedef struct packed {
        logic [4:0]         command;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] top_value;
        logic [6:0]         depth;
    } t_out_word;

    // data moves of one cell per cycle
    typedef enum logic [2:0] {
        DOP_HOLD    = 3'd0,
        DOP_SHIFTDN = 3'd1,
        DOP_SHIFTUP = 3'd2,
        DOP_UPLOAD  = 3'd3,
        DOP_LOAD0   = 3'd4,
        DOP_SWAP    = 3'd5,
        DOP_ROT     = 3'd6
    } t_data_op;

    typedef enum logic [1:0] {
        WOP_HOLD  = 2'd0,
        WOP_CLR   = 2'd1,
        WOP_SHIFT = 2'd2
    } t_win_op;

    typedef enum logic [1:0] {
        POP_HOLD  = 2'd0,
        POP_COPY  = 2'd1,
        POP_SHIFT = 2'd2
    } t_probe_op;

    typedef struct packed {
        t_data_op  data_op;
        t_win_op   win_op;
        t_probe_op probe_op;
    } t_cell_ctl;

endpackage

// ===== design/sou_cell.sv =====
// sou_cell: one stack entry with its probe copy and roll window bit
// depends on sou_pkg
`timescale 1ns / 1ps
module sou_cell import sou_pkg::*; (
    input  logic        i_clk,
    input  t_cell_ctl   i_ctl,
    input  logic        i_is_top,
    input  logic        i_is_second,
    input  logic [31:0] i_above_data,
    input  logic [31:0] i_below_data,
    input  logic [31:0] i_top_data,
    input  logic        i_above_win,
    input  logic        i_below_win,
    input  logic [31:0] i_below_probe,
    output logic [31:0] o_data,
    output logic        o_win,
    output logic [31:0] o_probe
);

    logic [31:0] r_data, n_data;
    logic        r_win, n_win;
    logic [31:0] r_probe, n_probe;

    always_comb begin
        n_data = r_data;
        case (i_ctl.data_op)
            DOP_SHIFTDN: n_data = i_above_data;
            DOP_SHIFTUP: n_data = i_below_data;
            DOP_UPLOAD:  n_data = i_is_top ? i_above_data : i_below_data;
            DOP_LOAD0:   if (i_is_top) n_data = i_above_data;
            DOP_SWAP: begin
                if (i_is_top) n_data = i_below_data;
                else if (i_is_second) n_data = i_above_data;
            end
            DOP_ROT: begin
                // last cell of the window wraps around to the old top
                if (r_win) n_data = i_below_win ? i_below_data : i_top_data;
            end
            default: n_data = r_data;
        endcase
    end

    always_comb begin
        case (i_ctl.win_op)
            WOP_CLR:   n_win = 1'b0;
            WOP_SHIFT: n_win = i_above_win;
            default:   n_win = r_win;
        endcase
        case (i_ctl.probe_op)
            POP_COPY:  n_probe = r_data;
            POP_SHIFT: n_probe = i_below_probe;
            default:   n_probe = r_probe;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_win   <= n_win;
        r_probe <= n_probe;
    end

    assign o_data  = r_data;
    assign o_win   = r_win;
    assign o_probe = r_probe;

endmodule

// ===== design/sou_div.sv =====
// sou_div: radix-2 restoring signed divider, one quotient bit per cycle
// truncating quotient, remainder follows the dividend sign; depends on sou_pkg
`timescale 1ns / 1ps
module sou_div import sou_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic [31:0] o_quot,
    output logic [31:0] o_rem
);

    logic [31:0] r_q;
    logic [31:0] r_r;
    logic [31:0] r_d;
    logic [4:0]  r_step;
    logic        r_busy;
    logic        r_negq, r_negr;
    logic [32:0] c_trial;
    logic [32:0] c_diff;

    assign c_trial = {r_r, r_q[31]};
    assign c_diff  = c_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 5'd1;
            if (r_step == 5'd31) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
            r_d    <= i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
            r_r    <= '0;
            r_negq <= i_dividend[31] ^ i_divisor[31];
            r_negr <= i_dividend[31];
        end else if (r_busy) begin
            if (!c_diff[32]) begin
                r_r <= c_diff[31:0];
                r_q <= {r_q[30:0], 1'b1};
            end else begin
                r_r <= c_trial[31:0];
                r_q <= {r_q[30:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_negq ? (32'd0 - r_q) : r_q;
    assign o_rem  = r_negr ? (32'd0 - r_r) : r_r;

endmodule

// ===== design/stack_operator_unit.sv =====
// stack_operator_unit: top level of the operand stack machine
// depends on sou_pkg, sou_cell, sou_div
`timescale 1ns / 1ps
// Usage
//   input channel: i_in_valid / o_in_stall carry one word {command, value};
//   a word is taken when valid is high and stall is low.
//   output channel: o_out_valid / i_out_stall carry one result word
//   {status, top_value, depth} for every input word, in order.
// Work per word, from acceptance to result valid:
//   push, pop, exch, dup, unknown codes: done in S_EXEC
//   add, sub, mul and compares: S_EXEC, S_ARITH, then S_WB
//   div, mod: S_EXEC, S_DIVW for the 32-step divider, then S_WB
//   index n: probe copy, probe chain shifted n + 1 times, load to top
//   roll n j: operands popped, window fill beside the divider for r = j mod n
//   in 0..n-1, then r one-place rotation steps
// One word is in the stack at a time; the next is taken once the result
// sits in the output register, so a waiting result does not block intake.
// Reset (synchronous, active low) empties the stack and drops any pending
// result. While the receiver stalls, the result holds and a second
// finished result waits inside until the output register frees.
// The stack itself is a row of cells, top first, that shift as one.
module stack_operator_unit import sou_pkg::*; #(
    parameter int STACK_DEPTH = SOU_STACK_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EXEC  = 8'b0000_0010,
        S_ARITH = 8'b0000_0100,
        S_DIVW  = 8'b0000_1000,
        S_WB    = 8'b0001_0000,
        S_PROBE = 8'b0010_0000,
        S_ROLLP = 8'b0100_0000,
        S_ROT   = 8'b1000_0000
    } t_state;

    // fin is folded into a flag so the state stays a single hot bit of eight
    t_state      r_state, n_state;
    logic        r_fin, n_fin;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [4:0]  r_cmd;
    logic [31:0] r_val;
    t_status     r_stat, n_stat;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_n, n_n;
    logic        r_winf, n_winf;     // roll: window fill phase
    logic [31:0] r_res, n_res;
    logic        r_ovalid;
    t_out_word   r_oword;

    t_cell_ctl   c_ctl;
    logic [31:0] c_ins;
    logic        c_div_start;
    logic [31:0] c_div_a, c_div_b;
    logic        w_div_busy;
    logic [31:0] w_quot, w_rem;
    logic [31:0] c_rmod;

    logic [31:0] w_data  [STACK_DEPTH];
    logic        w_win   [STACK_DEPTH];
    logic [31:0] w_probe [STACK_DEPTH];

    logic [31:0] c_top, c_sec;
    logic        c_out_free;

    assign c_top      = w_data[0];
    assign c_sec      = w_data[1];
    assign c_out_free = !r_ovalid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_fin;

    // rotation amount: truncated remainder moved into 0..n-1
    assign c_rmod = w_rem[31] ? (w_rem + 32'(r_n)) : w_rem;

    // ---------------------------------------------------------------
    // cell row, entry 0 is the top of stack
    // ---------------------------------------------------------------
    for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
        logic [31:0] w_above, w_below, w_below_probe;
        logic        w_above_win, w_below_win;
        if (gi == 0) begin : g_first
            assign w_above     = c_ins;
            assign w_above_win = 1'b1;
        end else begin : g_mid
            assign w_above     = w_data[gi-1];
            assign w_above_win = w_win[gi-1];
        end
        if (gi == STACK_DEPTH - 1) begin : g_last
            assign w_below       = '0;
            assign w_below_win   = 1'b0;
            assign w_below_probe = '0;
        end else begin : g_inner
            assign w_below       = w_data[gi+1];
            assign w_below_win   = w_win[gi+1];
            assign w_below_probe = w_probe[gi+1];
        end
        sou_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (c_ctl),
            .i_is_top     (gi == 0),
            .i_is_second  (gi == 1),
            .i_above_data (w_above),
            .i_below_data (w_below),
            .i_top_data   (c_top),
            .i_above_win  (w_above_win),
            .i_below_win  (w_below_win),
            .i_below_probe(w_below_probe),
            .o_data       (w_data[gi]),
            .o_win        (w_win[gi]),
            .o_probe      (w_probe[gi])
        );
    end

    sou_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (c_div_start),
        .i_dividend(c_div_a),
        .i_divisor (c_div_b),
        .o_busy    (w_div_busy),
        .o_quot    (w_quot),
        .o_rem     (w_rem)
    );

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_fin       = r_fin;
        n_cnt       = r_cnt;
        n_stat      = r_stat;
        n_k         = r_k;
        n_n         = r_n;
        n_winf      = r_winf;
        n_res       = r_res;
        c_ctl       = '{data_op: DOP_HOLD, win_op: WOP_HOLD, probe_op: POP_HOLD};
        c_ins       = r_res;
        c_div_start = 1'b0;
        c_div_a     = c_sec;
        c_div_b     = c_top;

        unique case (r_state)
            S_IDLE: begin
                // fin: result ready, wait for a free output register
                if (r_fin && c_out_free) n_fin = 1'b0;
                else if (!r_fin && i_in_valid) begin
                    n_state = S_EXEC;
                    n_stat  = ST_OK;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_fin   = 1'b1;
                case (t_cmd'(r_cmd))
                    CMD_PUSH: begin
                        if (r_cnt >= CW'(STACK_DEPTH)) n_stat = ST_OVER;
                        else begin
                            c_ins         = r_val;
                            c_ctl.data_op = DOP_SHIFTDN;
                            n_cnt         = r_cnt + 1'b1;
                        end
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_EQ, CMD_NEQ,
                    CMD_GT, CMD_GE, CMD_LT, CMD_LE: begin
                        if (r_cnt < CW'(2)) n_stat = ST_UNDER;
                        else begin
                            n_state = S_ARITH;
                            n_fin   = 1'b0;
                        end
                    end
                    CMD_DIV, CMD_MOD: begin
                        if (r_cnt < CW'(2)) n_stat = ST_UNDER;
                        else if (c_top == 32'd0) n_stat = ST_DIVZERO;
                        else begin
                            c_div_start = 1'b1;
                            n_state     = S_DIVW;
                            n_fin       = 1'b0;
                        end
                    end
                    CMD_POP: begin
                        if (r_cnt < CW'(1)) n_stat = ST_UNDER;
                        else begin
                            c_ctl.data_op = DOP_SHIFTUP;
                            n_cnt         = r_cnt - 1'b1;
                        end
                    end
                    CMD_EXCH: begin
                        if (r_cnt < CW'(2)) n_stat = ST_UNDER;
                        else c_ctl.data_op = DOP_SWAP;
                    end
                    CMD_DUP: begin
                        if (r_cnt < CW'(1)) n_stat = ST_UNDER;
                        else if (r_cnt >= CW'(STACK_DEPTH)) n_stat = ST_OVER;
                        else begin
                            c_ins         = c_top;
                            c_ctl.data_op = DOP_SHIFTDN;
                            n_cnt         = r_cnt + 1'b1;
                        end
                    end
                    CMD_INDEX: begin
                        if (r_cnt < CW'(1)) n_stat = ST_UNDER;
                        else if (c_top[31]) n_stat = ST_BADCOUNT;
                        else if (c_top >= 32'(r_cnt - 1'b1)) n_stat = ST_UNDER;
                        else begin
                            // probe copy, then shift n+1 places up to the top
                            c_ctl.probe_op = POP_COPY;
                            n_k            = CW'(c_top) + 1'b1;
                            n_state        = S_PROBE;
                            n_fin          = 1'b0;
                        end
                    end
                    CMD_ROLL: begin
                        if (r_cnt < CW'(2)) n_stat = ST_UNDER;
                        else if (c_sec[31]) n_stat = ST_BADCOUNT;
                        else if (c_sec > 32'(r_cnt - CW'(2))) n_stat = ST_UNDER;
                        else begin
                            n_res         = c_top;        // j
                            n_n           = CW'(c_sec);   // n
                            c_ctl.data_op = DOP_SHIFTUP;
                            c_ctl.win_op  = WOP_CLR;
                            n_cnt         = r_cnt - 1'b1;
                            n_state       = S_ROLLP;
                            n_fin         = 1'b0;
                        end
                    end
                    default: n_stat = ST_OK;
                endcase
            end
            S_ARITH: begin
                n_state = S_WB;
                case (t_cmd'(r_cmd))
                    CMD_ADD: n_res = c_sec + c_top;
                    CMD_SUB: n_res = c_sec - c_top;
                    CMD_MUL: n_res = c_sec * c_top;
                    CMD_EQ:  n_res = 32'(c_sec == c_top);
                    CMD_NEQ: n_res = 32'(c_sec != c_top);
                    CMD_GT:  n_res = 32'($signed(c_sec) > $signed(c_top));
                    CMD_GE:  n_res = 32'($signed(c_sec) >= $signed(c_top));
                    CMD_LT:  n_res = 32'($signed(c_sec) < $signed(c_top));
                    default: n_res = 32'($signed(c_sec) <= $signed(c_top));
                endcase
            end
            S_DIVW: begin
                if (!w_div_busy) begin
                    n_res   = (t_cmd'(r_cmd) == CMD_MOD) ? w_rem : w_quot;
                    n_state = S_WB;
                end
            end
            S_WB: begin
                // result replaces the second entry, the row moves up one
                c_ins         = r_res;
                c_ctl.data_op = DOP_UPLOAD;
                n_cnt         = r_cnt - 1'b1;
                n_state       = S_IDLE;
                n_fin         = 1'b1;
            end
            S_PROBE: begin
                if (r_k == '0) begin
                    c_ins         = w_probe[0];
                    c_ctl.data_op = DOP_LOAD0;
                    n_state       = S_IDLE;
                    n_fin         = 1'b1;
                end else begin
                    c_ctl.probe_op = POP_SHIFT;
                    n_k            = r_k - 1'b1;
                end
            end
            S_ROLLP: begin
                if (!r_winf) begin
                    // second operand pop, then window fill and j mod n
                    c_ctl.data_op = DOP_SHIFTUP;
                    n_cnt         = r_cnt - 1'b1;
                    if (r_n == '0) begin
                        n_state = S_IDLE;
                        n_fin   = 1'b1;
                    end else begin
                        c_div_start = 1'b1;
                        c_div_a     = r_res;
                        c_div_b     = 32'(r_n);
                        n_k         = r_n;
                        n_winf      = 1'b1;
                    end
                end else begin
                    if (r_k != '0) begin
                        c_ctl.win_op = WOP_SHIFT;
                        n_k          = r_k - 1'b1;
                    end else if (!w_div_busy) begin
                        n_k     = CW'(c_rmod);
                        n_winf  = 1'b0;
                        n_state = S_ROT;
                    end
                end
            end
            S_ROT: begin
                if (r_k == '0) begin
                    n_state = S_IDLE;
                    n_fin   = 1'b1;
                end else begin
                    c_ctl.data_op = DOP_ROT;
                    n_k           = r_k - 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fin    <= 1'b0;
            r_cnt    <= '0;
            r_winf   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
            r_cnt   <= n_cnt;
            r_winf  <= n_winf;
            if (r_state == S_IDLE && r_fin && c_out_free) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_stat <= n_stat;
        r_k    <= n_k;
        r_n    <= n_n;
        r_res  <= n_res;
        if (r_state == S_IDLE && !r_fin && i_in_valid) begin
            r_cmd <= i_in_word.command;
            r_val <= i_in_word.value;
        end
        if (r_state == S_IDLE && r_fin && c_out_free) begin
            r_oword.status    <= r_stat;
            r_oword.top_value <= (r_cnt != '0) ? c_top : 32'd0;
            r_oword.depth     <= 7'(r_cnt);
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

endmodule

// ===== design/sou_checker.sv =====
// sou_checker: port-level checks on the stack operator unit
// depends on sou_pkg; bound to stack_operator_unit below
`timescale 1ns / 1ps
module sou_checker import sou_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result changed");

    // only defined status codes come out
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.status <= ST_BADCOUNT))
        else $error("undefined status");

    // reset drops any pending result
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // one word at a time: intake closes right after a word is taken
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second word taken while busy");

endmodule

bind stack_operator_unit sou_checker u_sou_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_word  (i_in_word),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_word (o_out_word)
);

// ===== dv/stack_checker.sv =====
// stack_checker: watches both channels of stack_operator_unit, predicts each result
// word from its own copy of the operand stack and compares; depends on sou_pkg
`timescale 1ns / 1ps
module stack_checker import sou_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);
    logic [31:0] operand_stack [SOU_STACK_DEPTH];
    logic [31:0] roll_copy [SOU_STACK_DEPTH];
    int unsigned stack_size;
    t_out_word   expected_words [$];

    function automatic logic [2:0] arith_result(input logic [4:0] cmd,
        input logic signed [31:0] a, input logic signed [31:0] b,
        output logic [31:0] res);
        res = '0;
        case (cmd)
            CMD_ADD: res = a + b;
            CMD_SUB: res = a - b;
            CMD_MUL: res = a * b;
            CMD_DIV, CMD_MOD: begin
                if (b == 0) return ST_DIVZERO;
                if (a == 32'sh80000000 && b == -1) res = (cmd == CMD_DIV) ? a : 0;
                else res = (cmd == CMD_DIV) ? a / b : a % b;
            end
            CMD_EQ:  res = {31'd0, a == b};
            CMD_NEQ: res = {31'd0, a != b};
            CMD_GT:  res = {31'd0, a > b};
            CMD_GE:  res = {31'd0, a >= b};
            CMD_LT:  res = {31'd0, a < b};
            default: res = {31'd0, a <= b};
        endcase
        return ST_OK;
    endfunction

    // applies one command word to the local stack, returns the result word
    function automatic t_out_word apply_command(input t_in_word w);
        t_out_word o;
        logic [2:0] st;
        logic [31:0] res, t;
        longint n, j, r, rest;
        int unsigned base;
        st = ST_OK;
        case (w.command)
            CMD_PUSH: if (stack_size >= SOU_STACK_DEPTH) st = ST_OVER;
                else begin
                    operand_stack[stack_size] = w.value;
                    stack_size++;
                end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_EQ, CMD_NEQ, CMD_GT,
            CMD_GE, CMD_LT, CMD_LE: if (stack_size < 2) st = ST_UNDER;
                else begin
                    st = arith_result(w.command, operand_stack[stack_size-2],
                                      operand_stack[stack_size-1], res);
                    if (st == ST_OK) begin
                        operand_stack[stack_size-2] = res;
                        stack_size--;
                    end
                end
            CMD_POP: if (stack_size < 1) st = ST_UNDER; else stack_size--;
            CMD_EXCH: if (stack_size < 2) st = ST_UNDER;
                else begin
                    t = operand_stack[stack_size-1];
                    operand_stack[stack_size-1] = operand_stack[stack_size-2];
                    operand_stack[stack_size-2] = t;
                end
            CMD_DUP: if (stack_size < 1) st = ST_UNDER;
                else if (stack_size >= SOU_STACK_DEPTH) st = ST_OVER;
                else begin
                    operand_stack[stack_size] = operand_stack[stack_size-1];
                    stack_size++;
                end
            CMD_INDEX: if (stack_size < 1) st = ST_UNDER;
                else begin
                    n = longint'($signed(operand_stack[stack_size-1]));
                    rest = stack_size - 1;
                    if (n < 0) st = ST_BADCOUNT;
                    else if (n >= rest) st = ST_UNDER;
                    else operand_stack[stack_size-1] = operand_stack[rest-1-n];
                end
            CMD_ROLL: if (stack_size < 2) st = ST_UNDER;
                else begin
                    j = longint'($signed(operand_stack[stack_size-1]));
                    n = longint'($signed(operand_stack[stack_size-2]));
                    rest = stack_size - 2;
                    if (n < 0) st = ST_BADCOUNT;
                    else if (n > rest) st = ST_UNDER;
                    else begin
                        stack_size = rest;
                        if (n > 0) begin
                            base = rest - n;
                            r = ((j % n) + n) % n;
                            for (int i = 0; i < n; i++) roll_copy[i] = operand_stack[base+i];
                            // entry i from the top takes old entry (i + r) mod n
                            for (int i = 0; i < n; i++)
                                operand_stack[base+n-1-i] = roll_copy[n-1-((i+r)%n)];
                        end
                    end
                end
            default: ;
        endcase
        o.status = st;
        o.top_value = stack_size ? operand_stack[stack_size-1] : '0;
        o.depth = stack_size[6:0];
        return o;
    endfunction

    assign o_pending = expected_words.size();

    always @(posedge i_clk) begin
        t_out_word exp_w;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            stack_size = 0;
            expected_words.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word %h", i_out_word);
                    errs++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (exp_w.status !== i_out_word.status) begin
                        $error("status expected %0d actual %0d", exp_w.status,
                               i_out_word.status);
                        errs++;
                    end
                    if (exp_w.top_value !== i_out_word.top_value) begin
                        $error("top_value expected %0d actual %0d", exp_w.top_value,
                               i_out_word.top_value);
                        errs++;
                    end
                    if (exp_w.depth !== i_out_word.depth) begin
                        $error("depth expected %0d actual %0d", exp_w.depth,
                               i_out_word.depth);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
            if (i_in_valid && !i_in_stall)
                expected_words.push_back(apply_command(i_in_word));
        end
    end
endmodule

// ===== dv/testbench.sv =====
// testbench: stimulus and verdict for stack_operator_unit
// depends on sou_pkg, stack_operator_unit and stack_checker
`timescale 1ns / 1ps
module testbench;
    import sou_pkg::*;

    logic      clk = 0;
    logic      rst_n = 0;
    logic      in_valid = 0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 0;
    t_out_word out_word;
    int        fail_count, pending;
    int        idle_cycles = 0;
    int        words_sent = 0;
    int        model_depth = 0;   // rough depth to steer the random mix
    bit        quiet_phase = 0;   // long stretch with no idling on either side

    localparam int WATCHDOG = 20000;

    always #5 clk = ~clk;

    stack_operator_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_word(out_word)
    );

    stack_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_word(in_word),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_word(out_word),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall, random except in the quiet stretch
    always @(posedge clk)
        out_stall <= !quiet_phase && ($urandom_range(99) < 30);

    // watchdog on cycles without any accepted word
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog: no progress after %0d cycles", WATCHDOG);
            $display("testbench: FAIL");
            $finish;
        end
    end

    // send one word: optional random gap, then hold valid until taken
    task automatic send_word(input logic [4:0] cmd, input logic [31:0] val);
        while (!quiet_phase && $urandom_range(99) < 30) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_word  <= '{command: cmd, value: val};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
        // track depth loosely, good enough to steer pushes and pops
        if (cmd == CMD_PUSH || cmd == CMD_DUP) model_depth++;
        else if (cmd >= CMD_ADD && cmd <= CMD_POP) model_depth--;
        else if (cmd == CMD_ROLL) model_depth -= 2;
        if (model_depth < 0) model_depth = 0;
        if (model_depth > SOU_STACK_DEPTH) model_depth = SOU_STACK_DEPTH;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'hffffffff;
            3: return $urandom_range(8);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [4:0] cmd;
        int cnt;
        int wait_cycles;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty-stack underflows, extremes, div corner cases
        send_word(CMD_POP, 0);
        send_word(CMD_DUP, 0);
        send_word(CMD_INDEX, 0);
        send_word(CMD_ROLL, 0);
        send_word(5'd31, 32'hffffffff);          // unknown code ignored
        send_word(CMD_PUSH, 32'h80000000);
        send_word(CMD_EXCH, 0);                  // exch with one entry
        send_word(CMD_PUSH, 32'hffffffff);
        send_word(CMD_DIV, 0);                   // most negative over minus one
        send_word(CMD_PUSH, 32'h80000000);
        send_word(CMD_PUSH, 32'hffffffff);
        send_word(CMD_MOD, 0);
        send_word(CMD_PUSH, 0);
        send_word(CMD_DIV, 0);                   // zero divisor
        send_word(CMD_MOD, 0);
        send_word(CMD_PUSH, 32'hffffffff);
        send_word(CMD_INDEX, 0);                 // negative count
        send_word(CMD_PUSH, 5);
        send_word(CMD_INDEX, 0);                 // count beyond stack
        send_word(CMD_PUSH, 3);
        send_word(CMD_PUSH, 32'hfffffffe);
        send_word(CMD_ROLL, 0);                  // roll with negative shift
        send_word(CMD_PUSH, 0);
        send_word(CMD_PUSH, 7);
        send_word(CMD_ROLL, 0);                  // zero-length roll
        // fill to overflow, then push and dup on a full stack
        for (int i = 0; i < SOU_STACK_DEPTH + 1; i++) send_word(CMD_PUSH, $urandom);
        send_word(CMD_DUP, 0);
        send_word(CMD_PUSH, 32'hffffffff);
        send_word(CMD_ROLL, 0);                  // roll, large counts
        for (int i = 0; i < SOU_STACK_DEPTH; i++) send_word(CMD_POP, 0);

        // random: mostly well-formed sequences, some noise
        while (words_sent < 900) begin
            if (words_sent > 300 && words_sent < 500) quiet_phase = 1;
            else quiet_phase = 0;
            case ($urandom_range(9))
                0, 1, 2: begin                   // binary operator on fresh operands
                    send_word(CMD_PUSH, rand_value());
                    send_word(CMD_PUSH, rand_value());
                    send_word(5'($urandom_range(CMD_LE, CMD_ADD)), 0);
                end
                3: begin                         // index with a count in 0..model_depth
                    send_word(CMD_PUSH, $urandom_range(model_depth > 0 ? model_depth : 0));
                    send_word(CMD_INDEX, 0);
                end
                4: begin                         // roll of the top few entries
                    cnt = $urandom_range(model_depth > 8 ? 8 : model_depth);
                    send_word(CMD_PUSH, cnt);
                    send_word(CMD_PUSH, $urandom_range(1) ? $urandom_range(20)
                                                         : -$urandom_range(20));
                    send_word(CMD_ROLL, 0);
                end
                5: send_word(model_depth > 40 ? CMD_POP : CMD_PUSH, rand_value());
                6: send_word(5'($urandom_range(CMD_DUP, CMD_POP)), 0);
                7: send_word(model_depth > 2 ? CMD_POP : CMD_DUP, 0);
                8: send_word($urandom_range(1) ? 5'($urandom_range(31, 17))
                                               : 5'($urandom_range(CMD_LE, CMD_ADD)),
                             $urandom);
                default: send_word(CMD_PUSH, rand_value());
            endcase
        end
        in_valid <= 0;
        quiet_phase = 0;

        // drain, then a short tail to catch stray words
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("sent %0d words: all opcodes, unknown codes, under/overflow,", words_sent);
        $display("zero divisor, bad counts, index and roll, with random stalls");
        if (fail_count == 0) $display("testbench: PASS");
        else $display("testbench: FAIL");
        $finish;
    end
endmodule
